// File: rtl/id11_pkg.sv
// Package with the payload types, state type, constants and helper function of the ID check.
package id11_pkg;

  // ASCII codes that the format check looks for.
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiNine  = 8'h39;
  localparam logic [7:0] AsciiDot   = 8'h2E;
  localparam logic [7:0] AsciiDash  = 8'h2D;
  localparam logic [7:0] AsciiUpperK = 8'h4B;
  localparam logic [7:0] AsciiLowerK = 8'h6B;

  // Check value that stands for the letter K.
  localparam logic [3:0] CheckK = 4'd10;

  // Character positions in the fixed form DD.DDD.DDD-C.
  localparam logic [3:0] PosDotA    = 4'd2;
  localparam logic [3:0] PosDotB    = 4'd6;
  localparam logic [3:0] PosDash    = 4'd10;
  localparam logic [3:0] PosCheck   = 4'd11;
  localparam logic [3:0] PosLength  = 4'd12;
  localparam logic [3:0] PosSatur   = 4'd13;

  // Modulus and the reciprocal used to reduce the weighted sum (186 / 2048 ~ 1 / 11).
  localparam logic [8:0]  Modulus    = 9'd11;
  localparam logic [16:0] RecipMult  = 17'd186;
  localparam int unsigned RecipShift = 11;

  // Result codes.
  typedef enum logic [1:0] {
    VerdictValid    = 2'd0,
    VerdictFormat   = 2'd1,
    VerdictMismatch = 2'd2
  } verdict_e;

  // Input transfer payload.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_t;

  // Output transfer payload.
  typedef struct packed {
    verdict_e   verdict;
    logic [3:0] expected_check;
  } out_t;

  // Running state carried from one character to the next.
  typedef struct packed {
    logic [3:0] position;
    logic       format_good;
    logic [8:0] weighted_sum;
    logic [3:0] given_check;
  } state_t;

  localparam state_t StateReset = '{
    position:     4'd0,
    format_good:  1'b1,
    weighted_sum: 9'd0,
    given_check:  4'd0
  };

  // Weight of the digit at each position, counted 2..7 from the rightmost digit.
  function automatic logic [2:0] digit_weight(input logic [3:0] pos);
    logic [2:0] w;
    unique case (pos)
      4'd0:    w = 3'd3;
      4'd1:    w = 3'd2;
      4'd3:    w = 3'd7;
      4'd4:    w = 3'd6;
      4'd5:    w = 3'd5;
      4'd7:    w = 3'd4;
      4'd8:    w = 3'd3;
      4'd9:    w = 3'd2;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/id11_step.sv
// Per-character update of the check state and the verdict for a final character.
module id11_step (
  input  id11_pkg::in_t    item_i,
  input  id11_pkg::state_t state_i,
  output id11_pkg::state_t state_o,
  output id11_pkg::out_t   result_o
);

  logic [7:0]  chr;
  logic [3:0]  pos;
  logic        is_digit;
  logic [3:0]  digit_val;
  logic [6:0]  product;
  logic [16:0] quot_full;
  logic [8:0]  quot;
  logic [8:0]  rem_raw;
  logic [3:0]  rem;
  logic [3:0]  check_val;
  logic        length_ok;

  assign chr       = item_i.character;
  assign pos       = state_i.position;
  assign is_digit  = (chr >= id11_pkg::AsciiZero) && (chr <= id11_pkg::AsciiNine);
  assign digit_val = 4'(chr - id11_pkg::AsciiZero);
  assign product   = 7'(digit_val) * 7'(id11_pkg::digit_weight(pos));

  // Format check and state update for the character at the current position.
  always_comb begin
    state_o = state_i;
    if (pos >= id11_pkg::PosLength) begin
      state_o.format_good = 1'b0;
    end else if ((pos == id11_pkg::PosDotA) || (pos == id11_pkg::PosDotB)) begin
      if (chr != id11_pkg::AsciiDot) state_o.format_good = 1'b0;
    end else if (pos == id11_pkg::PosDash) begin
      if (chr != id11_pkg::AsciiDash) state_o.format_good = 1'b0;
    end else if (pos == id11_pkg::PosCheck) begin
      if (is_digit) begin
        state_o.given_check = digit_val;
      end else if ((chr == id11_pkg::AsciiUpperK) || (chr == id11_pkg::AsciiLowerK)) begin
        state_o.given_check = id11_pkg::CheckK;
      end else begin
        state_o.format_good = 1'b0;
      end
    end else begin
      if (is_digit) begin
        state_o.weighted_sum = state_i.weighted_sum + 9'(product);
      end else begin
        state_o.format_good = 1'b0;
      end
    end
    if (pos < id11_pkg::PosSatur) state_o.position = pos + 4'd1;
  end

  // Sum mod 11 by reciprocal multiply; the quotient is low by at most one.
  // The sum is final by the check position, so the stored sum is used.
  assign quot_full = 17'(state_i.weighted_sum) * id11_pkg::RecipMult;
  assign quot      = 9'(quot_full >> id11_pkg::RecipShift);
  assign rem_raw   = state_i.weighted_sum - 9'(quot * id11_pkg::Modulus);
  assign rem       = (rem_raw >= id11_pkg::Modulus) ? 4'(rem_raw - id11_pkg::Modulus)
                                                    : 4'(rem_raw);
  assign check_val = (rem == 4'd0) ? 4'd0 : 4'(id11_pkg::Modulus) - rem;

  // The string has exactly twelve characters when the check position is the last.
  assign length_ok = (pos == id11_pkg::PosCheck);

  always_comb begin
    if (!state_o.format_good || !length_ok) begin
      result_o.verdict        = id11_pkg::VerdictFormat;
      result_o.expected_check = 4'd0;
    end else begin
      result_o.verdict        = (check_val == state_o.given_check) ? id11_pkg::VerdictValid
                                                                   : id11_pkg::VerdictMismatch;
      result_o.expected_check = check_val;
    end
  end

endmodule

// File: rtl/id_mod11_check_digit_validator.sv
// Top level of the modulo-11 identity check validator: input register, state and result register.
//
//   Channel | Ports                          | Payload
//   --------+--------------------------------+---------------------------------
//   in      | in_valid_i, in_ready_o         | in_data_i  (character, last)
//   out     | out_valid_o, out_ready_i       | out_data_o (verdict, expected_check)
//
// One character per cycle is taken unless a final character waits for the result register. The
// result register is loaded when the character flagged last leaves the input register.
// Reset puts the running state to position zero, format good, sum and check zero.
// A stalled result holds only a final character in the input register; all other
// characters keep flowing while the result waits.
module id_mod11_check_digit_validator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  id11_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output id11_pkg::out_t out_data_o
);

  logic             s1_valid_q;
  id11_pkg::in_t    s1_data_q;
  id11_pkg::state_t state_q;
  id11_pkg::state_t state_next;
  id11_pkg::out_t   result;
  logic             out_valid_q;
  id11_pkg::out_t   out_q;
  logic             s1_drain;
  logic             in_xfer;

  // A non-final character always moves on; a final one needs a free result slot.
  assign s1_drain   = s1_valid_q && (!s1_data_q.last || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_drain;
  assign in_xfer    = in_valid_i && in_ready_o;

  id11_step u_step (
    .item_i   (s1_data_q),
    .state_i  (state_q),
    .state_o  (state_next),
    .result_o (result)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_drain) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) s1_data_q <= in_data_i;
  end

  // Running state; a final character returns it to the reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= id11_pkg::StateReset;
    end else if (s1_drain) begin
      state_q <= s1_data_q.last ? id11_pkg::StateReset : state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_drain && s1_data_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_drain && s1_data_q.last) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The position counter saturates at thirteen.
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.position <= id11_pkg::PosSatur)
    else $error("position counter above saturation");

  // A final character leaves the state at its reset value.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_drain && s1_data_q.last |=> state_q == id11_pkg::StateReset)
    else $error("state not cleared after final character");

  // A format verdict carries a zero check value.
  a_format_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.verdict == id11_pkg::VerdictFormat)
      |-> out_data_o.expected_check == 4'd0)
    else $error("format verdict with nonzero check value");

  // The computed check value stays in range 0..10.
  a_check_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.expected_check <= id11_pkg::CheckK)
    else $error("check value out of range");

endmodule
